// File: rtl/typed_handle_object_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Typed handle object table: assertion macros
// Shared assertion forms, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TYPED_HANDLE_OBJECT_TABLE_UNIT_DEFINES_SVH
`define TYPED_HANDLE_OBJECT_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THOT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define THOT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/thot_pkg.sv
// ----------------------------------------------------------------------------
// Typed handle object table package
// Operation codes, the table entry record and the per-cell command bundle.
// ----------------------------------------------------------------------------
package thot_pkg;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_NONE   = 2'd3
   } thot_kind_type;

   localparam int TYPE_W  = 4;
   localparam int HANDLE_W = 64;
   localparam int REF_W   = 64;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic [TYPE_W-1:0]   obj_type;
      logic [HANDLE_W-1:0] handle;
      logic [REF_W-1:0]    obj_ref;
   } thot_entry_type;

   typedef struct packed {
      logic capture;
      logic shift_up;
      logic shift_down;
      logic write_ref;
   } thot_cmd_type;

endpackage

// File: rtl/thot_req_if.sv
// ----------------------------------------------------------------------------
// Typed handle object table request channel
// Valid/ready channel carrying one table operation per request.
// ----------------------------------------------------------------------------
interface thot_req_if;
   import thot_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [TYPE_W-1:0]   object_type;
   logic [HANDLE_W-1:0] handle;
   logic [REF_W-1:0]    object_ref;

   modport source (output valid, kind, object_type, handle, object_ref, input ready);
   modport sink (input valid, kind, object_type, handle, object_ref, output ready);
endinterface

// File: rtl/thot_rsp_if.sv
// ----------------------------------------------------------------------------
// Typed handle object table response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface thot_rsp_if;
   import thot_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic               found;
   logic [REF_W-1:0]   found_ref;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, status, found, found_ref, entry_count, input ready);
   modport sink (input valid, status, found, found_ref, entry_count, output ready);
endinterface

// File: rtl/thot_cell.sv
// ----------------------------------------------------------------------------
// Typed handle object table cell
// Holds one table entry, compares it against the request key and shifts
// entries to and from its neighbors when the table grows or compacts.
// ----------------------------------------------------------------------------
module thot_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  thot_pkg::thot_cmd_type   cmd,
   input  logic                    live,
   input  logic                    tail,
   input  thot_pkg::thot_entry_type key_in,
   input  thot_pkg::thot_entry_type new_entry,
   input  thot_pkg::thot_entry_type prev_entry,
   input  thot_pkg::thot_entry_type next_entry,
   output thot_pkg::thot_entry_type entry,
   output logic                    hit
);
   import thot_pkg::*;

   thot_entry_type entry_ff;
   thot_entry_type entry_in;
   logic           hit_ff;
   logic           hit_in;

   always_comb begin
      hit_in = hit_ff;
      if (cmd.capture) begin
         hit_in = live && (entry_ff.obj_type == key_in.obj_type)
                  && (entry_ff.handle == key_in.handle);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.shift_up) begin
         entry_in = prev_entry;
      end else if (cmd.shift_down && tail) begin
         entry_in = next_entry;
      end else if (cmd.write_ref && hit_ff) begin
         entry_in.obj_ref = new_entry.obj_ref;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;
endmodule

// File: rtl/typed_handle_object_table_unit.sv
// ----------------------------------------------------------------------------
// Typed handle object table unit
// Keyed table of live objects built as a row of entry cells. Inserts append
// at the head by shifting the row, removes compact it by shifting down over
// the freed cell, and every cell compares its key in parallel.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_chan  in         kind, object_type, handle, object_ref
//  rsp_chan  out        status, found, found_ref, entry_count
//
//  The key compare in every cell is registered at acceptance, and the
//  update and result are registered in the apply state that follows.
//  Reset clears the live count; the entry cells need no clearing.
//  A stalled response holds the unit in its update cycle until it is taken.
// ----------------------------------------------------------------------------
`include "typed_handle_object_table_unit_defines.svh"

module typed_handle_object_table_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   thot_req_if.sink   req_chan,
   thot_rsp_if.source rsp_chan
);
   import thot_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type      state_ff;
   state_type      state_in;
   thot_kind_type  kind_ff;
   thot_entry_type op_entry_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic             rsp_valid_ff;
   logic             rsp_status_ff;
   logic             rsp_found_ff;
   logic [REF_W-1:0] rsp_found_ref_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic accept;
   logic apply_go;
   logic full;
   logic any_hit;
   logic status_in;
   logic found_in;
   logic [REF_W-1:0] found_ref_in;
   logic [REF_W-1:0] hit_ref;

   thot_entry_type key_in;
   thot_cmd_type   cmd;
   thot_entry_type cell_entry [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic [TABLE_DEPTH-1:0] tail_vec;
   logic [TABLE_DEPTH-1:0] live_vec;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign apply_go = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_chan.ready);
   assign full     = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      key_in.obj_type = req_chan.object_type;
      key_in.handle   = req_chan.handle;
      key_in.obj_ref  = req_chan.object_ref;
   end

   always_comb begin
      any_hit  = |hit_vec;
      tail_vec = ~(hit_vec - TABLE_DEPTH'(1));
      hit_ref  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_ref = hit_ref | (hit_vec[i] ? cell_entry[i].obj_ref : '0);
      end
   end

   always_comb begin
      cmd.capture    = accept;
      cmd.shift_up   = apply_go && (kind_ff == KIND_INSERT) && !any_hit && !full;
      cmd.shift_down = apply_go && (kind_ff == KIND_REMOVE) && any_hit;
      cmd.write_ref  = apply_go && (kind_ff == KIND_INSERT) && any_hit;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      thot_entry_type prev_entry;
      thot_entry_type next_entry;

      assign live_vec[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_entry = op_entry_ff;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      thot_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .live       (live_vec[i]),
         .tail       (tail_vec[i]),
         .key_in     (key_in),
         .new_entry  (op_entry_ff),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .hit        (hit_vec[i])
      );
   end

   always_comb begin
      found_in     = (kind_ff != KIND_NONE) && any_hit;
      status_in    = (kind_ff == KIND_INSERT) && !any_hit && full;
      found_ref_in = ((kind_ff == KIND_LOOKUP) && any_hit) ? hit_ref : '0;
      count_in     = count_ff;
      if (apply_go) begin
         if (cmd.shift_up) begin
            count_in = count_ff + CNT_W'(1);
         end else if (cmd.shift_down) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (apply_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= thot_kind_type'(req_chan.kind);
         op_entry_ff <= key_in;
      end
      if (apply_go) begin
         rsp_status_ff    <= status_in;
         rsp_found_ff     <= found_in;
         rsp_found_ref_ff <= found_ref_in;
         rsp_count_ff     <= COUNT_W'(count_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.found_ref   = rsp_found_ref_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   `THOT_ASSERT_SAME(a_hit_unique, state_ff == ST_APPLY, $onehot0(hit_vec))
   `THOT_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `THOT_ASSERT_NEXT(a_insert_grows, cmd.shift_up, count_ff == $past(count_ff) + CNT_W'(1))
   `THOT_ASSERT_SAME(a_refuse_full, apply_go && status_in, full && !found_in)
endmodule

// File: test/typed_handle_object_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Typed handle object table unit testbench
// Sends insert, lookup, remove and no-op requests to the table. The
// requests start with a directed set, then fill the table to capacity, then
// run random traffic over a shared pool of keys. A mirror of the live
// entries predicts every response, and each response is compared field by
// field in the order the requests were accepted. Both channels idle at
// random. The response side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module typed_handle_object_table_unit_tb;
   import thot_pkg::*;

   localparam int DEPTH        = 64;
   localparam int KEY_POOL     = 96;
   localparam int RANDOM_ITEMS = 1880;
   localparam int TIMEOUT_NS   = 5000000;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   typedef struct {
      logic               status;
      logic               found;
      logic [REF_W-1:0]   found_ref;
      logic [COUNT_W-1:0] entry_count;
   } table_result_type;

   class live_object_table;
      logic [TYPE_W-1:0]   slot_type [DEPTH];
      logic [HANDLE_W-1:0] slot_handle [DEPTH];
      logic [REF_W-1:0]    slot_ref [DEPTH];
      int                  live_entries = 0;
      int                  mismatch_count = 0;
      table_result_type    pending_results [$];

      function int find_entry(logic [TYPE_W-1:0] t, logic [HANDLE_W-1:0] h);
         for (int i = 0; i < live_entries; i++)
            if (slot_type[i] == t && slot_handle[i] == h) return i;
         return -1;
      endfunction

      function void note_request(thot_kind_type kind, logic [TYPE_W-1:0] t,
                                 logic [HANDLE_W-1:0] h, logic [REF_W-1:0] r);
         table_result_type res;
         int               slot;
         res.status    = 1'b0;
         res.found     = 1'b0;
         res.found_ref = '0;
         slot = find_entry(t, h);
         if (kind != KIND_NONE && slot >= 0) res.found = 1'b1;
         case (kind)
            KIND_INSERT: begin
               if (slot >= 0) begin
                  slot_ref[slot] = r;
               end else if (live_entries >= DEPTH) begin
                  res.status = 1'b1;
               end else begin
                  slot_type[live_entries]   = t;
                  slot_handle[live_entries] = h;
                  slot_ref[live_entries]    = r;
                  live_entries++;
               end
            end
            KIND_LOOKUP: begin
               if (slot >= 0) res.found_ref = slot_ref[slot];
            end
            KIND_REMOVE: begin
               if (slot >= 0) begin
                  live_entries--;
                  slot_type[slot]   = slot_type[live_entries];
                  slot_handle[slot] = slot_handle[live_entries];
                  slot_ref[slot]    = slot_ref[live_entries];
               end
            end
            default: ;
         endcase
         res.entry_count = live_entries[COUNT_W-1:0];
         pending_results.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_result(table_result_type got);
         table_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
         if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
         if (got.found_ref !== want.found_ref)
            report_mismatch($sformatf("found_ref %h, expected %h",
                                      got.found_ref, want.found_ref));
         if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      got.entry_count, want.entry_count));
      endtask
   endclass

   logic clock;
   logic reset;

   thot_req_if req_chan ();
   thot_rsp_if rsp_chan ();

   typed_handle_object_table_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   live_object_table    live_table = new;
   logic [TYPE_W-1:0]   pool_type [KEY_POOL];
   logic [HANDLE_W-1:0] pool_handle [KEY_POOL];
   bit                  no_idle = 1'b0;
   bit                  req_offering = 1'b0;
   int                  hold_cycles = 0;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] random64();
      return {$urandom, $urandom};
   endfunction

   function automatic void pick_key(thot_kind_type kind, output logic [TYPE_W-1:0] t,
                                    output logic [HANDLE_W-1:0] h);
      int idx;
      int roll;
      roll = $urandom_range(0, 99);
      if (kind != KIND_INSERT && live_table.live_entries > 0 && roll < 45) begin
         idx = $urandom_range(0, live_table.live_entries - 1);
         t = live_table.slot_type[idx];
         h = live_table.slot_handle[idx];
      end else if (roll < 87) begin
         idx = $urandom_range(0, KEY_POOL - 1);
         t = pool_type[idx];
         h = pool_handle[idx];
      end else begin
         t = 4'($urandom_range(0, 15));
         h = random64();
      end
   endfunction

   task automatic send_request(thot_kind_type kind, logic [TYPE_W-1:0] t,
                               logic [HANDLE_W-1:0] h, logic [REF_W-1:0] r);
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= kind;
      req_chan.object_type <= t;
      req_chan.handle      <= h;
      req_chan.object_ref  <= r;
      req_offering = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      live_table.note_request(kind, t, h, r);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         req_offering = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      if (req_offering) begin
         req_chan.valid <= 1'b0;
         req_offering = 1'b0;
      end
      while (live_table.pending_results.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, plus one long hold requested by the sender.
   initial begin : rsp_sink
      int               stall_left;
      table_result_type got;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status      = rsp_chan.status;
            got.found       = rsp_chan.found;
            got.found_ref   = rsp_chan.found_ref;
            got.entry_count = rsp_chan.entry_count;
            live_table.check_result(got);
         end
         if (hold_cycles > 0) begin
            stall_left = hold_cycles;
            hold_cycles = 0;
         end else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [TYPE_W-1:0]   t;
      logic [HANDLE_W-1:0] h;
      thot_kind_type       kind;
      traffic_mode_type    mode;
      int                  sent;
      int                  seg_len;
      int                  roll;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.kind        <= KIND_NONE;
      req_chan.object_type <= '0;
      req_chan.handle      <= '0;
      req_chan.object_ref  <= '0;

      for (int i = 0; i < KEY_POOL; i++) begin
         pool_type[i] = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 5))
            0: pool_handle[i] = 64'($urandom_range(0, 7));
            1: pool_handle[i] = ~64'($urandom_range(0, 7));
            2: begin
               if (i > 0) begin
                  pool_handle[i] = pool_handle[i-1];
                  pool_type[i]   = pool_type[i-1] + 4'd1;
               end else begin
                  pool_handle[i] = random64();
               end
            end
            3: begin
               if (i > 0) pool_handle[i] = pool_handle[i-1] ^ (64'd1 << $urandom_range(0, 63));
               else pool_handle[i] = random64();
            end
            default: pool_handle[i] = random64();
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, hits and misses, replace, no-op and compaction.
      send_request(KIND_NONE, 4'd0, 64'd0, '1);
      send_request(KIND_LOOKUP, 4'd0, 64'd0, '1);
      send_request(KIND_REMOVE, 4'd0, 64'd0, '0);
      send_request(KIND_INSERT, 4'd0, 64'd0, '1);
      send_request(KIND_INSERT, 4'd15, '1, '0);
      send_request(KIND_LOOKUP, 4'd0, 64'd0, '0);
      send_request(KIND_LOOKUP, 4'd15, '1, '1);
      send_request(KIND_INSERT, 4'd15, '1, 64'h5555_5555_5555_5555);
      send_request(KIND_LOOKUP, 4'd15, '1, '0);
      send_request(KIND_LOOKUP, 4'd14, '1, '0);
      send_request(KIND_LOOKUP, 4'd0, 64'd1, '0);
      send_request(KIND_NONE, 4'd15, '1, '1);
      send_request(KIND_REMOVE, 4'd0, 64'd0, '1);
      send_request(KIND_LOOKUP, 4'd15, '1, '0);
      send_request(KIND_REMOVE, 4'd0, 64'd0, '0);
      send_request(KIND_REMOVE, 4'd15, '1, '0);
      send_request(KIND_LOOKUP, 4'd15, '1, '0);
      send_request(KIND_INSERT, 4'd5, 64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(KIND_INSERT, 4'd10, 64'h7fff_ffff_ffff_ffff, 64'd1);
      send_request(KIND_LOOKUP, 4'd10, 64'h7fff_ffff_ffff_ffff, '0);

      // Fill to capacity with distinct keys, then exercise the full table.
      sent = 0;
      while (live_table.live_entries < DEPTH) begin
         send_request(KIND_INSERT, 4'(sent), {58'(random64() >> 6), 6'(sent)}, random64());
         sent++;
      end
      send_request(KIND_INSERT, 4'd3, 64'hdead_beef_0000_0001, random64());
      send_request(KIND_INSERT, live_table.slot_type[7], live_table.slot_handle[7], '1);
      send_request(KIND_LOOKUP, live_table.slot_type[7], live_table.slot_handle[7], '0);
      send_request(KIND_REMOVE, live_table.slot_type[0], live_table.slot_handle[0], '0);
      send_request(KIND_INSERT, 4'd3, 64'hdead_beef_0000_0001, random64());
      sent += 5;

      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(40, 150);
         mode    = traffic_mode_type'($urandom_range(0, 2));
         no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            case (mode)
               MODE_FILL: begin
                  kind = roll < 75 ? KIND_INSERT : roll < 88 ? KIND_LOOKUP :
                         roll < 95 ? KIND_REMOVE : KIND_NONE;
               end
               MODE_DRAIN: begin
                  kind = roll < 15 ? KIND_INSERT : roll < 40 ? KIND_LOOKUP :
                         roll < 95 ? KIND_REMOVE : KIND_NONE;
               end
               default: begin
                  kind = roll < 40 ? KIND_INSERT : roll < 70 ? KIND_LOOKUP :
                         roll < 95 ? KIND_REMOVE : KIND_NONE;
               end
            endcase
            pick_key(kind, t, h);
            send_request(kind, t, h, random64());
            sent++;
            if (sent == 600) hold_cycles = 300;
            if (sent == 1200) wait_for_results();
         end
         if ($urandom_range(0, 4) == 0) wait_for_results();
      end

      @(posedge clock);
      wait_for_results();
      repeat (20) @(posedge clock);
      if (live_table.mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
